[rtl/core/plt_pkg.sv]
package plt_pkg;

    localparam int PAGE_SLOTS_DEF = 16;
    localparam int THREADS_DEF    = 8;
    localparam int COUNT_BITS     = 8;

    localparam int CMD_W     = 2;
    localparam int REQ_W     = 3;
    localparam int PAGE_W    = 32;
    localparam int TOT_OUT_W = 11;
    localparam int CNT_OUT_W = 8;

    typedef enum logic [1:0] {
        CMD_ACQ_SHARED,
        CMD_ACQ_EXCL,
        CMD_REL_SHARED,
        CMD_REL_EXCL
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_BUSY,
        STAT_FULL,
        STAT_LIMIT
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_LOOK,
        ST_EXEC
    } state_t;

endpackage

[rtl/core/page_latch_table.sv]
// Each item passes through the engine as a lookup step and then an update step, and the
// engine takes no new item until it is through with the last one; a result is ready when
// its update is done, later when earlier items wait in the queue or a result is not yet popped.
// This follows from the registered read of the per-thread count memory before its update.
// After reset the count memory is cleared entry by entry, one per slot and thread, while
// full stays high; slot state, queues and the configuration register reset at once.
module page_latch_table
    import plt_pkg::*;
#(
    parameter int PAGE_SLOTS = PAGE_SLOTS_DEF,
    parameter int THREADS    = THREADS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 push,
    output logic                 full,
    input  logic [CMD_W-1:0]     command,
    input  logic [REQ_W-1:0]     requester,
    input  logic [PAGE_W-1:0]    page_number,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           status,
    output logic [TOT_OUT_W-1:0] page_shared_total,
    output logic [CNT_OUT_W-1:0] page_exclusive_depth,
    output logic [CNT_OUT_W-1:0] holder_shared_count,
    output logic [CNT_OUT_W-1:0] holder_exclusive_count
);

    localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;

    logic              reentrancy_reg;
    logic              hold;
    logic              q_avail;
    logic              q_take;
    cmd_t              q_cmd;
    logic [TW-1:0]     q_thread;
    logic [PAGE_W-1:0] q_page;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reentrancy_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            reentrancy_reg <= cfg_wdata;
        end
    end

    plt_front #(
        .THREADS (THREADS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .requester   (requester),
        .page_number (page_number),
        .hold        (hold),
        .q_avail     (q_avail),
        .q_take      (q_take),
        .q_cmd       (q_cmd),
        .q_thread    (q_thread),
        .q_page      (q_page)
    );

    plt_back #(
        .PAGE_SLOTS (PAGE_SLOTS),
        .THREADS    (THREADS)
    ) u_back (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .reentrancy_enable      (reentrancy_reg),
        .hold                   (hold),
        .q_avail                (q_avail),
        .q_take                 (q_take),
        .q_cmd                  (q_cmd),
        .q_thread               (q_thread),
        .q_page                 (q_page),
        .empty                  (empty),
        .pop                    (pop),
        .status                 (status),
        .page_shared_total      (page_shared_total),
        .page_exclusive_depth   (page_exclusive_depth),
        .holder_shared_count    (holder_shared_count),
        .holder_exclusive_count (holder_exclusive_count)
    );

endmodule

[rtl/core/plt_front.sv]
module plt_front
    import plt_pkg::*;
#(
    parameter int THREADS = THREADS_DEF,
    localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CMD_W-1:0]  command,
    input  logic [REQ_W-1:0]  requester,
    input  logic [PAGE_W-1:0] page_number,
    input  logic              hold,
    output logic              q_avail,
    input  logic              q_take,
    output cmd_t              q_cmd,
    output logic [TW-1:0]     q_thread,
    output logic [PAGE_W-1:0] q_page
);

    cmd_t              cmd_reg    [2];
    logic [TW-1:0]     thread_reg [2];
    logic [PAGE_W-1:0] page_reg   [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [TW-1:0]     thread_norm;
    logic              accept;
    logic              take;

    always_comb
    begin
        logic [REQ_W-1:0] w;
        w = requester;
        for (int i = 0; i < 4; i++)
        begin
            if (int'(w) >= THREADS)
            begin
                w = w - REQ_W'(THREADS);
            end
        end
        thread_norm = TW'(w);
    end

    assign full   = (count_reg == 2'd2) || hold;
    assign accept = push && !full;
    assign take   = q_take && (count_reg != 2'd0);

    assign q_avail  = (count_reg != 2'd0);
    assign q_cmd    = cmd_reg[rd_ptr_reg];
    assign q_thread = thread_reg[rd_ptr_reg];
    assign q_page   = page_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg[wr_ptr_reg]    <= cmd_t'(command);
            thread_reg[wr_ptr_reg] <= thread_norm;
            page_reg[wr_ptr_reg]   <= page_number;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (accept && !take)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (take && !accept)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[rtl/core/plt_back.sv]
module plt_back
    import plt_pkg::*;
#(
    parameter int PAGE_SLOTS = PAGE_SLOTS_DEF,
    parameter int THREADS    = THREADS_DEF,
    localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 reentrancy_enable,
    output logic                 hold,
    input  logic                 q_avail,
    output logic                 q_take,
    input  cmd_t                 q_cmd,
    input  logic [TW-1:0]        q_thread,
    input  logic [PAGE_W-1:0]    q_page,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           status,
    output logic [TOT_OUT_W-1:0] page_shared_total,
    output logic [CNT_OUT_W-1:0] page_exclusive_depth,
    output logic [CNT_OUT_W-1:0] holder_shared_count,
    output logic [CNT_OUT_W-1:0] holder_exclusive_count
);

    localparam int CW    = COUNT_BITS;
    localparam int SW    = $clog2(THREADS * ((1 << CW) - 1) + 1);
    localparam int SLW   = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
    localparam int DEPTH = PAGE_SLOTS * THREADS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CW-1:0] CMAX = {CW{1'b1}};

    logic [PAGE_W-1:0] slot_page_reg   [PAGE_SLOTS];
    logic [SW-1:0]     slot_shared_reg [PAGE_SLOTS];
    logic [CW-1:0]     slot_excl_reg   [PAGE_SLOTS];
    logic [TW-1:0]     slot_owner_reg  [PAGE_SLOTS];

    logic [2*CW-1:0]   holder_mem [DEPTH];

    state_t            state_reg, state_next;
    logic [AW:0]       clr_cnt_reg;
    logic [SLW-1:0]    slot_reg;
    logic              hit_reg;
    logic              alloc_reg;
    logic              tfull_reg;
    cmd_t              cmd_reg;
    logic [TW-1:0]     thread_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [AW-1:0]     addr_reg;
    logic [2*CW-1:0]   rd_data_reg;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [SW-1:0]     out_tot_reg;
    logic [CW-1:0]     out_ex_reg;
    logic [CW-1:0]     out_hs_reg;
    logic [CW-1:0]     out_hx_reg;

    logic              look_go;
    logic              exec_go;
    logic              found;
    logic              free_found;
    logic [SLW-1:0]    hit_idx;
    logic [SLW-1:0]    free_idx;
    logic [AW-1:0]     look_addr;
    logic              active;

    logic [SW-1:0]     tot_cur, tot_n;
    logic [CW-1:0]     ex_cur, ex_n;
    logic [TW-1:0]     own_cur, own_n;
    logic [CW-1:0]     hs_cur, hs_n;
    logic [CW-1:0]     hx_cur, hx_n;
    status_t           stat_n;
    logic              foreign;

    logic [SW+TOT_OUT_W-1:0] tot_ext;
    logic [CW+CNT_OUT_W-1:0] ex_ext;
    logic [CW+CNT_OUT_W-1:0] hs_ext;
    logic [CW+CNT_OUT_W-1:0] hx_ext;

    always_comb
    begin
        found      = 1'b0;
        free_found = 1'b0;
        hit_idx    = '0;
        free_idx   = '0;
        for (int s = PAGE_SLOTS - 1; s >= 0; s--)
        begin
            if ((slot_shared_reg[s] != '0) || (slot_excl_reg[s] != '0))
            begin
                if (slot_page_reg[s] == q_page)
                begin
                    found   = 1'b1;
                    hit_idx = SLW'(s);
                end
            end
            else
            begin
                free_found = 1'b1;
                free_idx   = SLW'(s);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        look_go    = 1'b0;
        exec_go    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == (AW+1)'(DEPTH - 1))
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (q_avail)
                begin
                    look_go    = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || pop)
                begin
                    exec_go    = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign hold   = (state_reg == ST_CLEAR);
    assign q_take = look_go;

    always_comb
    begin
        logic [SLW-1:0] sel;
        sel       = found ? hit_idx : free_idx;
        look_addr = AW'(int'(sel) * THREADS + int'(q_thread));
    end

    assign active  = hit_reg || alloc_reg;
    assign tot_cur = slot_shared_reg[slot_reg];
    assign ex_cur  = slot_excl_reg[slot_reg];
    assign own_cur = slot_owner_reg[slot_reg];
    assign hs_cur  = rd_data_reg[2*CW-1:CW];
    assign hx_cur  = rd_data_reg[CW-1:0];
    assign foreign = (ex_cur != '0) && (own_cur != thread_reg);

    always_comb
    begin
        tot_n  = tot_cur;
        ex_n   = ex_cur;
        own_n  = own_cur;
        hs_n   = hs_cur;
        hx_n   = hx_cur;
        stat_n = STAT_OK;
        case (cmd_reg)
            CMD_ACQ_SHARED:
            begin
                if (foreign)
                begin
                    stat_n = STAT_BUSY;
                end
                else if (hs_cur == CMAX)
                begin
                    stat_n = STAT_LIMIT;
                end
                else
                begin
                    hs_n  = hs_cur + CW'(1);
                    tot_n = tot_cur + SW'(1);
                end
            end
            CMD_ACQ_EXCL:
            begin
                if (foreign)
                begin
                    stat_n = STAT_BUSY;
                end
                else if (tot_cur > SW'(hs_cur))
                begin
                    stat_n = STAT_BUSY;
                end
                else if (!reentrancy_enable && (hx_cur != '0))
                begin
                    stat_n = STAT_BUSY;
                end
                else if ((hx_cur == CMAX) || (ex_cur == CMAX))
                begin
                    stat_n = STAT_LIMIT;
                end
                else
                begin
                    if (ex_cur == '0)
                    begin
                        own_n = thread_reg;
                    end
                    ex_n = ex_cur + CW'(1);
                    hx_n = hx_cur + CW'(1);
                end
            end
            CMD_REL_SHARED:
            begin
                if (hs_cur != '0)
                begin
                    hs_n = hs_cur - CW'(1);
                    if (tot_cur != '0)
                    begin
                        tot_n = tot_cur - SW'(1);
                    end
                end
            end
            default:
            begin
                if (hx_cur != '0)
                begin
                    hx_n = hx_cur - CW'(1);
                    if (ex_cur != '0)
                    begin
                        ex_n = ex_cur - CW'(1);
                    end
                    if (ex_n == '0)
                    begin
                        own_n = '0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < PAGE_SLOTS; s++)
            begin
                slot_page_reg[s]   <= '0;
                slot_shared_reg[s] <= '0;
                slot_excl_reg[s]   <= '0;
                slot_owner_reg[s]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + (AW+1)'(1);
            end
            if (exec_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            if (exec_go && active)
            begin
                if (alloc_reg)
                begin
                    slot_page_reg[slot_reg] <= page_reg;
                end
                slot_shared_reg[slot_reg] <= tot_n;
                slot_excl_reg[slot_reg]   <= ex_n;
                slot_owner_reg[slot_reg]  <= own_n;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (look_go)
        begin
            hit_reg    <= found;
            alloc_reg  <= !found && free_found && (q_cmd == CMD_ACQ_SHARED ||
                                                   q_cmd == CMD_ACQ_EXCL);
            tfull_reg  <= !found && !free_found && (q_cmd == CMD_ACQ_SHARED ||
                                                    q_cmd == CMD_ACQ_EXCL);
            slot_reg   <= found ? hit_idx : free_idx;
            cmd_reg    <= q_cmd;
            thread_reg <= q_thread;
            page_reg   <= q_page;
            addr_reg   <= look_addr;
            rd_data_reg <= holder_mem[look_addr];
        end
        if (state_reg == ST_CLEAR)
        begin
            holder_mem[clr_cnt_reg[AW-1:0]] <= '0;
        end
        else if (exec_go && active)
        begin
            holder_mem[addr_reg] <= {hs_n, hx_n};
        end
        if (exec_go)
        begin
            if (active)
            begin
                out_status_reg <= stat_n;
                out_tot_reg    <= tot_n;
                out_ex_reg     <= ex_n;
                out_hs_reg     <= hs_n;
                out_hx_reg     <= hx_n;
            end
            else
            begin
                out_status_reg <= tfull_reg ? STAT_FULL : STAT_OK;
                out_tot_reg    <= '0;
                out_ex_reg     <= '0;
                out_hs_reg     <= '0;
                out_hx_reg     <= '0;
            end
        end
    end

    assign tot_ext = {{TOT_OUT_W{1'b0}}, out_tot_reg};
    assign ex_ext  = {{CNT_OUT_W{1'b0}}, out_ex_reg};
    assign hs_ext  = {{CNT_OUT_W{1'b0}}, out_hs_reg};
    assign hx_ext  = {{CNT_OUT_W{1'b0}}, out_hx_reg};

    assign empty                  = !out_valid_reg;
    assign status                 = out_status_reg;
    assign page_shared_total      = tot_ext[TOT_OUT_W-1:0];
    assign page_exclusive_depth   = ex_ext[CNT_OUT_W-1:0];
    assign holder_shared_count    = hs_ext[CNT_OUT_W-1:0];
    assign holder_exclusive_count = hx_ext[CNT_OUT_W-1:0];

endmodule
